FILE: rtl/ppe_pkg.sv
// Shared types and constants of the palette pixel expander.
package ppe_pkg;

   // Palette geometry
   localparam int DEFAULT_PALETTE_DEPTH = 256;
   localparam int COLOR_W               = 24;

   // Configuration register indexes and reset values
   typedef enum logic [1:0] {
      CSR_BITS_CODE  = 2'd0,
      CSR_ROW_WIDTH  = 2'd1,
      CSR_ALIGN_MASK = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam logic [1:0]  BITS_CODE_RESET  = 2'd3;
   localparam logic [15:0] ROW_WIDTH_RESET  = 16'd1;
   localparam logic [3:0]  ALIGN_MASK_RESET = 4'd0;

   // Input item operations
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DATA = 1'b1
   } opcode_type;

   typedef logic [COLOR_W-1:0] color_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] entry_index;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic       row_end;
      logic       last;
   } rsp_type;

   // Palette write port
   typedef struct packed {
      logic       en;
      logic [7:0] index;
      color_type  color;
   } pal_wr_type;

endpackage

FILE: rtl/palette_pixel_expander_unit.sv
// Top level of the palette pixel expander: row tracking, index expansion, output queue.
//
//   channel | dir | handshake              | payload
//   req_    | in  | req_valid / req_stall  | req_type (load entry or data byte)
//   rsp_    | out | rsp_valid / rsp_stall  | rsp_type (one pixel)
//   csr_    | in  | csr_valid / csr_ready  | csr_index, csr_data
//
// One pixel leaves per cycle while the output is not stalled, set by the single palette
// read port: a data byte holds the input until its last index is issued; a load writes at once.
// After its index is issued, a pixel color passes the registered palette read, then the queue.
// Synchronous reset clears the palette valid bits at once; no clearing pass.
// A stalled output fills a two-entry queue, then issue and the input stop.
module palette_pixel_expander_unit
   import ppe_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Configuration registers
   logic [1:0]  bits_code_ff;
   logic [15:0] row_width_ff;
   logic [3:0]  align_mask_ff;

   // Row counters
   logic [15:0] col_ff,  col_in;
   logic [16:0] bcnt_ff, bcnt_in;

   // Expander
   logic [7:0]  sh_ff,     sh_in;
   logic [3:0]  rem_ff,    rem_in;
   logic        rowend_ff, rowend_in;

   // Read stage
   logic        rd_valid_ff, rd_last_ff, rd_rowend_ff;

   // Output queue
   rsp_type     q_ff [2];
   logic        q_wr_ptr_ff, q_rd_ptr_ff;
   logic [1:0]  q_cnt_ff;

   logic        req_accept, data_accept, load_accept;
   logic        pop, push, issue;
   logic [3:0]  per_byte, n_pix;
   logic [15:0] avail;
   logic [16:0] col_sum;
   logic        row_end_acc;
   logic [18:0] bit_len;
   logic [18:0] bit_len_rnd;
   logic [16:0] stride_sum, stride;
   logic [16:0] bcnt_next;
   logic [7:0]  pix_index;
   logic [7:0]  sh_next;
   color_type   pix_color;
   pal_wr_type  pal_wr;
   rsp_type     push_item;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_code_ff  <= BITS_CODE_RESET;
         row_width_ff  <= ROW_WIDTH_RESET;
         align_mask_ff <= ALIGN_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BITS_CODE:  bits_code_ff  <= csr_data[1:0];
            CSR_ROW_WIDTH:  row_width_ff  <= csr_data;
            CSR_ALIGN_MASK: align_mask_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Handshakes
   assign pop   = rsp_valid && !rsp_stall;
   assign issue = (rem_ff != 4'd0) &&
                  (({1'b0, q_cnt_ff} + {2'b0, rd_valid_ff}) < (3'd2 + {2'b0, pop}));
   assign req_stall   = !((rem_ff == 4'd0) || ((rem_ff == 4'd1) && issue));
   assign req_accept  = req_valid && !req_stall;
   assign data_accept = req_accept && (req_payload.opcode == OP_DATA);
   assign load_accept = req_accept && (req_payload.opcode == OP_LOAD);

   // Pixels this byte gives, and whether it ends the row
   assign per_byte = 4'd8 >> bits_code_ff;
   assign avail    = row_width_ff - col_ff;
   always_comb begin
      if (col_ff >= row_width_ff) begin
         n_pix = 4'd0;
      end else if (avail < {12'b0, per_byte}) begin
         n_pix = avail[3:0];
      end else begin
         n_pix = per_byte;
      end
   end
   assign col_sum     = {1'b0, col_ff} + {13'b0, n_pix};
   assign row_end_acc = (n_pix != 4'd0) && (col_sum >= {1'b0, row_width_ff});

   // Aligned row stride in bytes
   assign bit_len     = {3'b0, row_width_ff} << bits_code_ff;
   assign bit_len_rnd = bit_len + 19'd7;
   assign stride_sum  = {1'b0, bit_len_rnd[18:3]} + {13'b0, align_mask_ff};
   assign stride      = stride_sum & ~{13'b0, align_mask_ff};
   assign bcnt_next   = bcnt_ff + 17'd1;

   // Advance row counters on each data byte
   always_comb begin
      col_in  = col_ff;
      bcnt_in = bcnt_ff;
      if (data_accept) begin
         if (bcnt_next >= stride) begin
            col_in  = '0;
            bcnt_in = '0;
         end else begin
            col_in  = col_sum[15:0];
            bcnt_in = bcnt_next;
         end
      end
   end

   // Take the top index bits of the shifted byte
   always_comb begin
      case (bits_code_ff)
         2'd0: begin
            pix_index = {7'b0, sh_ff[7]};
            sh_next   = {sh_ff[6:0], 1'b0};
         end
         2'd1: begin
            pix_index = {6'b0, sh_ff[7:6]};
            sh_next   = {sh_ff[5:0], 2'b0};
         end
         2'd2: begin
            pix_index = {4'b0, sh_ff[7:4]};
            sh_next   = {sh_ff[3:0], 4'b0};
         end
         default: begin
            pix_index = sh_ff;
            sh_next   = 8'd0;
         end
      endcase
   end

   // Load a new byte or advance to the next index
   always_comb begin
      sh_in     = sh_ff;
      rem_in    = rem_ff;
      rowend_in = rowend_ff;
      if (data_accept) begin
         sh_in     = req_payload.data_byte;
         rem_in    = n_pix;
         rowend_in = row_end_acc;
      end else if (issue) begin
         sh_in  = sh_next;
         rem_in = rem_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff     <= sh_in;
      rowend_ff <= rowend_in;
      if (reset) begin
         rem_ff  <= '0;
         col_ff  <= '0;
         bcnt_ff <= '0;
      end else begin
         rem_ff  <= rem_in;
         col_ff  <= col_in;
         bcnt_ff <= bcnt_in;
      end
   end

   // Palette write from load items
   assign pal_wr.en    = load_accept;
   assign pal_wr.index = req_payload.entry_index;
   assign pal_wr.color = {req_payload.in_red, req_payload.in_green, req_payload.in_blue};

   ppe_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .rd_index (pix_index),
      .rd_color (pix_color)
   );

   // Carry pixel flags alongside the palette read
   always_ff @(posedge clock) begin
      rd_last_ff   <= (rem_ff == 4'd1);
      rd_rowend_ff <= (rem_ff == 4'd1) && rowend_ff;
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   // Queue finished pixels for transfer
   assign push                = rd_valid_ff;
   assign push_item.pix_red   = pix_color[23:16];
   assign push_item.pix_green = pix_color[15:8];
   assign push_item.pix_blue  = pix_color[7:0];
   assign push_item.row_end   = rd_rowend_ff;
   assign push_item.last      = rd_last_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
         q_cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= ~q_wr_ptr_ff;
         end
         if (pop) begin
            q_rd_ptr_ff <= ~q_rd_ptr_ff;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_valid   = (q_cnt_ff != 2'd0);
   assign rsp_payload = q_ff[q_rd_ptr_ff];

endmodule

FILE: rtl/ppe_palette.sv
// Palette store: synchronous memory with per-entry valid bits and registered read.
module ppe_palette
   import ppe_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  pal_wr_type wr,
   input  logic [7:0] rd_index,
   output color_type  rd_color
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   color_type               mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] valid_ff;
   color_type               rd_data_ff;
   logic                    rd_hit_ff;

   logic wr_in_range;
   logic rd_in_range;

   assign wr_in_range = {1'b0, wr.index} < 9'(PALETTE_DEPTH);
   assign rd_in_range = {1'b0, rd_index} < 9'(PALETTE_DEPTH);

   // Write entry and read port; a same-edge read sees the old entry
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_index[IDX_W-1:0]];
      if (wr.en && wr_in_range) begin
         mem[wr.index[IDX_W-1:0]] <= wr.color;
      end
   end

   // Track written entries; reset clears them all at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         rd_hit_ff <= rd_in_range && valid_ff[rd_index[IDX_W-1:0]];
         if (wr.en && wr_in_range) begin
            valid_ff[wr.index[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Unwritten or out-of-range entries read as black
   assign rd_color = rd_hit_ff ? rd_data_ff : '0;

endmodule

FILE: test/palette_pixel_expander_unit_tb.sv
// Testbench for palette_pixel_expander_unit: palette loads and row expansion under random pacing.
module palette_pixel_expander_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [15:0] csr_data    = '0;

   palette_pixel_expander_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // Mirror of the block's state and registers
   color_type   palette_mirror [DEFAULT_PALETTE_DEPTH];
   logic [15:0] mirror_column;
   logic [16:0] mirror_byte_count;
   logic [1:0]  cfg_bits_code;
   logic [15:0] cfg_row_width;
   logic [3:0]  cfg_align_mask;

   req_type req_backlog [$];
   rsp_type expected_pixels [$];
   int      items_queued   = 0;
   int      items_taken    = 0;
   int      fail_count     = 0;
   int      sender_idle    = 0;
   int      receiver_stall = 0;
   bit      req_took       = 1'b0;
   int      quiet_cycles   = 0;

   // Bytes per row including alignment padding
   function automatic int unsigned row_stride();
      int unsigned data_bytes;
      int unsigned m;
      data_bytes = ((32'(cfg_row_width) << cfg_bits_code) + 7) >> 3;
      m = 32'(cfg_align_mask);
      return (data_bytes + m) & ~m & 32'h1FFFF;
   endfunction

   // Work out the pixels that one accepted transfer yields
   task automatic predict_pixels(req_type item);
      int unsigned bpp;
      int unsigned per_byte;
      int unsigned shift;
      logic [7:0]  idx;
      color_type   colour;
      rsp_type     burst [8];
      int          n;
      int          p;
      if (item.opcode == OP_LOAD) begin
         palette_mirror[item.entry_index] = {item.in_red, item.in_green, item.in_blue};
         return;
      end
      bpp = 1 << cfg_bits_code;
      per_byte = 8 >> cfg_bits_code;
      n = 0;
      for (p = 0; p < per_byte && mirror_column < cfg_row_width; p++) begin
         shift = 8 - bpp * (p + 1);
         idx = 8'((item.data_byte >> shift) & ((1 << bpp) - 1));
         colour = palette_mirror[idx];
         mirror_column = mirror_column + 16'd1;
         burst[n].pix_red   = colour[23:16];
         burst[n].pix_green = colour[15:8];
         burst[n].pix_blue  = colour[7:0];
         burst[n].row_end   = (mirror_column >= cfg_row_width);
         burst[n].last      = 1'b0;
         n++;
      end
      if (n > 0) burst[n-1].last = 1'b1;
      for (p = 0; p < n; p++) expected_pixels.push_back(burst[p]);
      // Wrap to a new row at the end of the stride
      mirror_byte_count = mirror_byte_count + 17'd1;
      if (32'(mirror_byte_count) >= row_stride()) begin
         mirror_byte_count = '0;
         mirror_column = '0;
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: record input transfers and check each output transfer
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_took = !reset && req_valid && !req_stall;
      if (req_took) begin
         predict_pixels(req_payload);
         items_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel %h", rsp_payload);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pix_red",   want.pix_red,   rsp_payload.pix_red);
            check_field("pix_green", want.pix_green, rsp_payload.pix_green);
            check_field("pix_blue",  want.pix_blue,  rsp_payload.pix_blue);
            check_field("row_end",   want.row_end,   rsp_payload.row_end);
            check_field("last",      want.last,      rsp_payload.last);
         end
      end
   end

   // Driver: hold a stalled transfer, otherwise issue the next item or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (req_backlog.size() > 0 && $urandom_range(99) >= sender_idle) begin
            req_payload <= req_backlog.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("palette_pixel_expander_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_item(req_type item);
      req_backlog.push_back(item);
      items_queued++;
   endtask

   function automatic req_type load_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
      req_type item;
      item = req_type'({$urandom, $urandom});
      item.opcode      = OP_LOAD;
      item.entry_index = idx;
      item.in_red      = r;
      item.in_green    = g;
      item.in_blue     = b;
      return item;
   endfunction

   function automatic req_type data_item(logic [7:0] value);
      req_type item;
      item = req_type'({$urandom, $urandom});
      item.opcode    = OP_DATA;
      item.data_byte = value;
      return item;
   endfunction

   // Register write; mirror it once the transfer completes
   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BITS_CODE:  cfg_bits_code  = value[1:0];
         CSR_ROW_WIDTH:  cfg_row_width  = value;
         CSR_ALIGN_MASK: cfg_align_mask = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off until every item is taken and every pixel has come out
   task automatic drain(int extra);
      while (items_taken != items_queued || expected_pixels.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_pace(int idle_pct, int stall_pct);
      sender_idle    = idle_pct;
      receiver_stall = stall_pct;
   endtask

   task automatic configure(logic [1:0] bits, logic [15:0] width, logic [3:0] mask);
      csr_write(CSR_BITS_CODE, 16'(bits));
      csr_write(CSR_ROW_WIDTH, width);
      csr_write(CSR_ALIGN_MASK, 16'(mask));
   endtask

   // Random phase: mostly data bytes with palette loads mixed in
   task automatic random_phase(int count);
      logic [15:0] width;
      logic [3:0]  mask;
      int          pick;
      int          k;
      pick = $urandom_range(15);
      if (pick == 0) width = 16'd0;
      else if (pick == 1) width = 16'hFFFF;
      else if (pick == 2) width = 16'($urandom_range(65535));
      else width = 16'($urandom_range(1, 24));
      if ($urandom_range(3) == 0) mask = 4'($urandom_range(15));
      else mask = 4'((1 << $urandom_range(4)) - 1);
      if ($urandom_range(3) == 0) csr_write(CSR_UNUSED, 16'($urandom));
      configure(2'($urandom_range(3)), width, mask);
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < 80) add_item(data_item(8'($urandom)));
         else add_item(load_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end
   endtask

   initial begin
      int ph;
      foreach (palette_mirror[i]) palette_mirror[i] = '0;
      mirror_column     = '0;
      mirror_byte_count = '0;
      cfg_bits_code     = BITS_CODE_RESET;
      cfg_row_width     = ROW_WIDTH_RESET;
      cfg_align_mask    = ALIGN_MASK_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: one pixel per byte, palette extremes
      add_item(load_item(8'd0, 8'h00, 8'h00, 8'h00));
      add_item(load_item(8'd255, 8'hFF, 8'hFF, 8'hFF));
      add_item(load_item(8'd1, 8'h80, 8'h01, 8'hC3));
      add_item(load_item(8'd2, 8'h3C, 8'h7E, 8'h5A));
      add_item(data_item(8'hFF));
      add_item(data_item(8'h00));
      add_item(data_item(8'h01));
      drain(SETTLE_CYCLES);

      // One bit per pixel, ten pixel rows padded to four bytes
      configure(2'd0, 16'd10, 4'd3);
      add_item(data_item(8'hA5));
      add_item(data_item(8'h5A));
      add_item(data_item(8'hFF));
      add_item(data_item(8'h00));
      add_item(data_item(8'hFE));
      drain(SETTLE_CYCLES);

      // Zero row width with a zero stride: every byte dropped
      csr_write(CSR_UNUSED, 16'hFFFF);
      configure(2'd1, 16'd0, 4'd0);
      add_item(data_item(8'hE4));
      add_item(data_item(8'h1B));
      drain(SETTLE_CYCLES);

      // Four bits per pixel under an irregular alignment mask
      configure(2'd2, 16'd5, 4'd10);
      add_item(data_item(8'h12));
      add_item(data_item(8'hF0));
      add_item(data_item(8'h0F));
      add_item(data_item(8'h33));
      add_item(data_item(8'h44));
      add_item(data_item(8'h21));
      drain(SETTLE_CYCLES);

      // Widest row, widest alignment
      configure(2'd3, 16'hFFFF, 4'd15);
      add_item(data_item(8'hFF));
      add_item(data_item(8'h00));
      add_item(data_item(8'h01));
      add_item(data_item(8'h02));
      drain(SETTLE_CYCLES);

      // Random phases, cycling through the pacing modes
      for (ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: set_pace(0, 0);
            1: set_pace(72, 0);
            2: set_pace(0, 72);
            default: set_pace(24, 24);
         endcase
         random_phase(44);
         drain(SETTLE_CYCLES);
      end

      drain(2 * SETTLE_CYCLES);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", expected_pixels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("palette_pixel_expander_unit verification clean");
      end else begin
         $display("palette_pixel_expander_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ppe_pkg.sv
rtl/ppe_palette.sv
rtl/palette_pixel_expander_unit.sv
test/palette_pixel_expander_unit_tb.sv
